[rtl/core/dcrnl_pkg.sv]
// Package: shared constants, codes, state and control types of the neighbor linker.
`default_nettype none
package dcrnl_pkg;

  localparam int DEF_MAX_PARTICLES = 1024;
  localparam int DEF_MAX_LINKS     = 8;

  localparam int IDX_W    = 10;
  localparam int POS_W    = 16;
  localparam int PCNT_W   = 11;
  localparam int LIM_W    = 36;
  localparam int SLOT_W   = 3;
  localparam int LEN_W    = 17;
  localparam int SKIP_W   = 10;
  localparam int FILL_W   = 4;
  localparam int SQ_W     = 32;
  localparam int D2_W     = 34;
  localparam int RES_CAP  = 8;
  localparam int K_W      = 4;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 64;

  localparam logic [PCNT_W-1:0] PCNT_RESET = 11'd100;
  localparam logic [LIM_W-1:0]  LIM_RESET  = 36'd8028;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_VISIT = 1'b1;

  localparam logic REG_PCOUNT = 1'b0;
  localparam logic REG_LIMIT  = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ_A,
    ST_CHECK_A,
    ST_SCAN,
    ST_DRAIN,
    ST_WRITE_A,
    ST_SQ_START,
    ST_SQ_WAIT,
    ST_PUSH,
    ST_NOLINK
  } state_t;

  typedef struct packed {
    logic clear_wr;
    logic in_ready;
    logic init_scan;
    logic issue;
    logic write_a;
    logic sq_start;
    logic push_link;
    logic push_nolink;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic visit_beat;
    logic scan_ok;
    logic b_lt_n;
    logic stop;
    logic pipe_busy;
    logic k_zero;
    logic sq_done;
    logic out_free;
    logic last_entry;
  } status_t;

endpackage
`default_nettype wire

[rtl/core/dcrnl_ifs.sv]
// Interfaces: input item channel and result channel of the neighbor linker.
`default_nettype none
interface dcrnl_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 func;
  logic [dcrnl_pkg::IDX_W-1:0]          particle_index;
  logic signed [dcrnl_pkg::POS_W-1:0]   pos_x;
  logic signed [dcrnl_pkg::POS_W-1:0]   pos_y;
  logic signed [dcrnl_pkg::POS_W-1:0]   pos_z;
  modport source (output valid, func, particle_index, pos_x, pos_y, pos_z, input ready);
  modport sink (input valid, func, particle_index, pos_x, pos_y, pos_z, output ready);
endinterface

interface dcrnl_out_if;
  logic                          valid;
  logic                          ready;
  logic                          linked;
  logic [dcrnl_pkg::IDX_W-1:0]   source_index;
  logic [dcrnl_pkg::IDX_W-1:0]   partner_index;
  logic [dcrnl_pkg::SLOT_W-1:0]  source_slot;
  logic [dcrnl_pkg::SLOT_W-1:0]  partner_slot;
  logic [dcrnl_pkg::LEN_W-1:0]   link_length;
  logic                          source_full;
  logic [dcrnl_pkg::SKIP_W-1:0]  skipped_full;
  logic                          last;
  modport source (output valid, linked, source_index, partner_index, source_slot,
                  partner_slot, link_length, source_full, skipped_full, last,
                  input ready);
  modport sink (input valid, linked, source_index, partner_index, source_slot,
                partner_slot, link_length, source_full, skipped_full, last,
                output ready);
endinterface
`default_nettype wire

[rtl/core/dcrnl_isqrt.sv]
// Iterative integer square root, one root bit per cycle.
`default_nettype none
module dcrnl_isqrt (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [dcrnl_pkg::D2_W-1:0]    value,
  output logic                               busy,
  output logic [dcrnl_pkg::LEN_W-1:0]        root
);
  localparam int REM_W = dcrnl_pkg::LEN_W + 4;
  localparam int CNT_W = $clog2(dcrnl_pkg::LEN_W + 1);

  logic [dcrnl_pkg::D2_W-1:0] val;
  logic [REM_W-1:0]           rem;
  logic [CNT_W-1:0]           cnt;
  logic [REM_W-1:0]           rem_sh;
  logic [REM_W-1:0]           trial;

  always_comb begin
    rem_sh = {rem[REM_W-3:0], val[dcrnl_pkg::D2_W-1 -: 2]};
    trial  = {{(REM_W-dcrnl_pkg::LEN_W-2){1'b0}}, root, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(dcrnl_pkg::LEN_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val  <= value;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      val <= {val[dcrnl_pkg::D2_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[dcrnl_pkg::LEN_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[dcrnl_pkg::LEN_W-2:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

[rtl/core/dcrnl_dp.sv]
// Datapath: position and fill memories, distance pipeline, link buffer, result register.
`default_nettype none
module dcrnl_dp #(
  parameter int MAX_PARTICLES = dcrnl_pkg::DEF_MAX_PARTICLES,
  parameter int MAX_LINKS     = dcrnl_pkg::DEF_MAX_LINKS
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire dcrnl_pkg::cmd_t                cmd,
  output dcrnl_pkg::status_t                  st,
  input  wire logic [dcrnl_pkg::PCNT_W-1:0]   particle_count,
  input  wire logic [dcrnl_pkg::LIM_W-1:0]    max_dist_sq,
  dcrnl_in_if.sink                            in_ch,
  dcrnl_out_if.source                         out_ch
);
  localparam int AW    = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int CW    = ((AW > dcrnl_pkg::PCNT_W) ? AW : dcrnl_pkg::PCNT_W) + 1;
  localparam int PW    = 3 * dcrnl_pkg::POS_W;
  localparam int BUF_W = $clog2(dcrnl_pkg::RES_CAP);
  localparam logic [CW-1:0] MAXP = CW'(MAX_PARTICLES);
  localparam logic [dcrnl_pkg::FILL_W-1:0] MAXL = dcrnl_pkg::FILL_W'(MAX_LINKS);

  logic [PW-1:0]                  pos_mem [MAX_PARTICLES];
  logic [dcrnl_pkg::FILL_W-1:0]   fill_mem [MAX_PARTICLES];
  logic [PW-1:0]                  pos_rd;
  logic [dcrnl_pkg::FILL_W-1:0]   fill_rd;

  logic [AW-1:0]                  clr_cnt;
  logic [dcrnl_pkg::IDX_W-1:0]    a_idx;
  logic                           a_ok;
  logic [PW-1:0]                  pa;
  logic [dcrnl_pkg::FILL_W-1:0]   fill_a;
  logic                           full_flag;
  logic [CW-1:0]                  b;
  logic [dcrnl_pkg::K_W-1:0]      k;
  logic [dcrnl_pkg::K_W-1:0]      ri;
  logic [dcrnl_pkg::SKIP_W-1:0]   skipped;

  logic                           v1, v2, v3;
  logic [CW-1:0]                  b1, b2, b3;
  logic [dcrnl_pkg::FILL_W-1:0]   fb2, fb3;
  logic [dcrnl_pkg::SQ_W-1:0]     sqx, sqy, sqz;
  logic [dcrnl_pkg::D2_W-1:0]     d2;

  logic [dcrnl_pkg::IDX_W-1:0]    buf_b    [dcrnl_pkg::RES_CAP];
  logic [dcrnl_pkg::SLOT_W-1:0]   buf_sa   [dcrnl_pkg::RES_CAP];
  logic [dcrnl_pkg::SLOT_W-1:0]   buf_sb   [dcrnl_pkg::RES_CAP];
  logic [dcrnl_pkg::D2_W-1:0]     buf_d2   [dcrnl_pkg::RES_CAP];

  logic                           sq_busy;
  logic [dcrnl_pkg::LEN_W-1:0]    sq_root;

  logic [CW-1:0]                  a_ext, in_ext, n_eff;
  logic [AW-1:0]                  a_addr, in_addr, raddr;
  logic                           in_ok, in_beat, load_wr;
  logic                           near, do_link, do_skip;
  logic                           fill_we;
  logic [AW-1:0]                  fill_wa;
  logic [dcrnl_pkg::FILL_W-1:0]   fill_wd;
  logic signed [dcrnl_pkg::POS_W:0] dx, dy, dz;
  logic signed [2*dcrnl_pkg::POS_W+1:0] px, py, pz;

  function automatic logic [dcrnl_pkg::D2_W-1:0] D2_W_ext(input logic [dcrnl_pkg::SQ_W-1:0] v);
    D2_W_ext = {{(dcrnl_pkg::D2_W-dcrnl_pkg::SQ_W){1'b0}}, v};
  endfunction

  always_comb begin
    in_ext  = CW'(in_ch.particle_index);
    in_ok   = in_ext < MAXP;
    in_addr = in_ext[AW-1:0];
    a_ext   = CW'(a_idx);
    a_addr  = a_ext[AW-1:0];
    in_beat = in_ch.valid && in_ch.ready;
    load_wr = in_beat && (in_ch.func == dcrnl_pkg::FUNC_LOAD) && in_ok;
    n_eff   = (CW'(particle_count) > MAXP) ? MAXP : CW'(particle_count);
    raddr   = cmd.issue ? b[AW-1:0] : a_addr;

    st.clear_done = clr_cnt == AW'(MAX_PARTICLES - 1);
    st.visit_beat = in_ch.valid && (in_ch.func == dcrnl_pkg::FUNC_VISIT);
    st.scan_ok    = a_ok && (fill_rd < MAXL) && (max_dist_sq != '0);
    st.b_lt_n     = b < n_eff;
    st.stop       = (fill_a >= MAXL) || (k == dcrnl_pkg::K_W'(dcrnl_pkg::RES_CAP));
    st.pipe_busy  = v1 || v2 || v3;
    st.k_zero     = k == '0;
    st.sq_done    = !sq_busy;
    st.out_free   = !out_ch.valid || out_ch.ready;
    st.last_entry = (ri + 1'b1) == k;

    near    = {{(dcrnl_pkg::LIM_W-dcrnl_pkg::D2_W){1'b0}}, d2} <= max_dist_sq;
    do_link = v3 && !st.stop && near && (fb3 < MAXL);
    do_skip = v3 && !st.stop && near && (fb3 >= MAXL);

    fill_we = 1'b1;
    fill_wa = clr_cnt;
    fill_wd = '0;
    if (cmd.clear_wr) begin
      fill_wa = clr_cnt;
    end else if (load_wr) begin
      fill_wa = in_addr;
    end else if (do_link) begin
      fill_wa = b3[AW-1:0];
      fill_wd = fb3 + 1'b1;
    end else if (cmd.write_a) begin
      fill_wa = a_addr;
      fill_wd = fill_a;
    end else begin
      fill_we = 1'b0;
    end

    dx = $signed({pa[15], pa[15:0]})  - $signed({pos_rd[15], pos_rd[15:0]});
    dy = $signed({pa[31], pa[31:16]}) - $signed({pos_rd[31], pos_rd[31:16]});
    dz = $signed({pa[47], pa[47:32]}) - $signed({pos_rd[47], pos_rd[47:32]});
    px = dx * dx;
    py = dy * dy;
    pz = dz * dz;
  end

  assign in_ch.ready = cmd.in_ready;

  always_ff @(posedge clk) begin
    if (load_wr) begin
      pos_mem[in_addr] <= {in_ch.pos_z, in_ch.pos_y, in_ch.pos_x};
    end
    if (fill_we) begin
      fill_mem[fill_wa] <= fill_wd;
    end
    pos_rd  <= pos_mem[raddr];
    fill_rd <= fill_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear_wr && !st.clear_done) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // visit bookkeeping
  always_ff @(posedge clk) begin
    if (in_beat && (in_ch.func == dcrnl_pkg::FUNC_VISIT)) begin
      a_idx <= in_ch.particle_index;
      a_ok  <= in_ok;
    end
    if (cmd.init_scan) begin
      pa        <= pos_rd;
      fill_a    <= fill_rd;
      full_flag <= !a_ok || (fill_rd >= MAXL);
      b         <= '0;
      k         <= '0;
      skipped   <= '0;
    end else begin
      if (cmd.issue) begin
        b <= b + 1'b1;
      end
      if (do_link) begin
        buf_b[k[BUF_W-1:0]]  <= b3[dcrnl_pkg::IDX_W-1:0];
        buf_sa[k[BUF_W-1:0]] <= fill_a[dcrnl_pkg::SLOT_W-1:0];
        buf_sb[k[BUF_W-1:0]] <= fb3[dcrnl_pkg::SLOT_W-1:0];
        buf_d2[k[BUF_W-1:0]] <= d2;
        k      <= k + 1'b1;
        fill_a <= fill_a + 1'b1;
      end
      if (do_skip && (skipped != '1)) begin
        skipped <= skipped + 1'b1;
      end
    end
    if (cmd.write_a) begin
      ri <= '0;
    end else if (cmd.push_link) begin
      ri <= ri + 1'b1;
    end
  end

  // distance pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= cmd.issue && (b != a_ext);
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    b1  <= b;
    b2  <= b1;
    fb2 <= fill_rd;
    sqx <= px[dcrnl_pkg::SQ_W-1:0];
    sqy <= py[dcrnl_pkg::SQ_W-1:0];
    sqz <= pz[dcrnl_pkg::SQ_W-1:0];
    b3  <= b2;
    fb3 <= fb2;
    d2  <= D2_W_ext(sqx) + D2_W_ext(sqy) + D2_W_ext(sqz);
  end

  dcrnl_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.sq_start),
    .value (buf_d2[ri[BUF_W-1:0]]),
    .busy  (sq_busy),
    .root  (sq_root)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (cmd.push_link || cmd.push_nolink) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_link) begin
      out_ch.linked        <= 1'b1;
      out_ch.source_index  <= a_idx;
      out_ch.partner_index <= buf_b[ri[BUF_W-1:0]];
      out_ch.source_slot   <= buf_sa[ri[BUF_W-1:0]];
      out_ch.partner_slot  <= buf_sb[ri[BUF_W-1:0]];
      out_ch.link_length   <= sq_root;
      out_ch.source_full   <= 1'b0;
      out_ch.skipped_full  <= skipped;
      out_ch.last          <= st.last_entry;
    end else if (cmd.push_nolink) begin
      out_ch.linked        <= 1'b0;
      out_ch.source_index  <= a_idx;
      out_ch.partner_index <= '0;
      out_ch.source_slot   <= '0;
      out_ch.partner_slot  <= '0;
      out_ch.link_length   <= '0;
      out_ch.source_full   <= full_flag;
      out_ch.skipped_full  <= skipped;
      out_ch.last          <= 1'b1;
    end
  end
endmodule
`default_nettype wire

[rtl/core/dcrnl_ctrl.sv]
// Controller: sequences clearing, visit scan, drain and result delivery.
`default_nettype none
module dcrnl_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire dcrnl_pkg::status_t  st,
  output dcrnl_pkg::cmd_t          cmd
);
  dcrnl_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dcrnl_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      dcrnl_pkg::ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (st.clear_done) begin
          state_next = dcrnl_pkg::ST_IDLE;
        end
      end
      dcrnl_pkg::ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (st.visit_beat) begin
          state_next = dcrnl_pkg::ST_READ_A;
        end
      end
      dcrnl_pkg::ST_READ_A: begin
        state_next = dcrnl_pkg::ST_CHECK_A;
      end
      dcrnl_pkg::ST_CHECK_A: begin
        cmd.init_scan = 1'b1;
        state_next = st.scan_ok ? dcrnl_pkg::ST_SCAN : dcrnl_pkg::ST_NOLINK;
      end
      dcrnl_pkg::ST_SCAN: begin
        cmd.issue = st.b_lt_n && !st.stop;
        if (!cmd.issue) begin
          state_next = dcrnl_pkg::ST_DRAIN;
        end
      end
      dcrnl_pkg::ST_DRAIN: begin
        if (!st.pipe_busy) begin
          state_next = dcrnl_pkg::ST_WRITE_A;
        end
      end
      dcrnl_pkg::ST_WRITE_A: begin
        cmd.write_a = 1'b1;
        state_next = st.k_zero ? dcrnl_pkg::ST_NOLINK : dcrnl_pkg::ST_SQ_START;
      end
      dcrnl_pkg::ST_SQ_START: begin
        cmd.sq_start = 1'b1;
        state_next = dcrnl_pkg::ST_SQ_WAIT;
      end
      dcrnl_pkg::ST_SQ_WAIT: begin
        if (st.sq_done) begin
          state_next = dcrnl_pkg::ST_PUSH;
        end
      end
      dcrnl_pkg::ST_PUSH: begin
        if (st.out_free) begin
          cmd.push_link = 1'b1;
          state_next = st.last_entry ? dcrnl_pkg::ST_IDLE : dcrnl_pkg::ST_SQ_START;
        end
      end
      dcrnl_pkg::ST_NOLINK: begin
        if (st.out_free) begin
          cmd.push_nolink = 1'b1;
          state_next = dcrnl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = dcrnl_pkg::ST_IDLE;
      end
    endcase
  end
endmodule
`default_nettype wire

[rtl/core/degree_capped_radius_neighbor_linker.sv]
// Top level: register port, controller and datapath of the neighbor linker.
//
//   channel   dir   handshake          beat carries
//   in_ch     in    valid/ready        func, particle_index, pos_x/y/z
//   out_ch    out   valid/ready        one result (link or visit summary)
//   apb       in    psel/penable/...   particle_count @0x0, max_dist_sq @0x8
//
// A visit scans the partners below particle_count, one distance test per cycle through
// the position memory read port, then runs the bit-serial square root and one push per
// link. After reset a clearing pass zeroes the fill counts; no item is taken meanwhile.
// A stalled result holds in the output register.
`default_nettype none
module degree_capped_radius_neighbor_linker #(
  parameter int MAX_PARTICLES = dcrnl_pkg::DEF_MAX_PARTICLES,
  parameter int MAX_LINKS     = dcrnl_pkg::DEF_MAX_LINKS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [dcrnl_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [dcrnl_pkg::DATA_W-1:0]  pwdata,
  output logic [dcrnl_pkg::DATA_W-1:0]       prdata,
  output logic                               pready,
  dcrnl_in_if.sink                           in_ch,
  dcrnl_out_if.source                        out_ch
);
  logic [dcrnl_pkg::PCNT_W-1:0] particle_count;
  logic [dcrnl_pkg::LIM_W-1:0]  max_dist_sq;
  dcrnl_pkg::cmd_t              cmd;
  dcrnl_pkg::status_t           st;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      particle_count <= dcrnl_pkg::PCNT_RESET;
      max_dist_sq    <= dcrnl_pkg::LIM_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[3] == dcrnl_pkg::REG_PCOUNT) begin
        particle_count <= pwdata[dcrnl_pkg::PCNT_W-1:0];
      end else begin
        max_dist_sq <= pwdata[dcrnl_pkg::LIM_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[3] == dcrnl_pkg::REG_LIMIT) begin
      prdata = {{(dcrnl_pkg::DATA_W-dcrnl_pkg::LIM_W){1'b0}}, max_dist_sq};
    end else begin
      prdata = {{(dcrnl_pkg::DATA_W-dcrnl_pkg::PCNT_W){1'b0}}, particle_count};
    end
  end

  dcrnl_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .cmd (cmd)
  );

  dcrnl_dp #(
    .MAX_PARTICLES (MAX_PARTICLES),
    .MAX_LINKS     (MAX_LINKS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .particle_count (particle_count),
    .max_dist_sq    (max_dist_sq),
    .in_ch          (in_ch),
    .out_ch         (out_ch)
  );
endmodule
`default_nettype wire

[rtl/core/dcrnl_checker.sv]
// Checker: port-level assertions on the result channel, bound to the top level.
`default_nettype none
module dcrnl_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic                          linked,
  input wire logic                          source_full,
  input wire logic [dcrnl_pkg::SKIP_W-1:0]  skipped_full,
  input wire logic                          last
);
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_hold_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(last) && $stable(linked))
    else $error("result beat changed while stalled");

  a_summary_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !linked |-> last)
    else $error("visit summary not marked last");

  a_link_not_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && linked |-> !source_full)
    else $error("link reported for full source");

  a_full_no_skip: assert property (@(posedge clk) disable iff (rst)
    out_valid && source_full |-> (skipped_full == '0) && !linked)
    else $error("full source reported skipped partners");
endmodule

bind degree_capped_radius_neighbor_linker dcrnl_checker u_dcrnl_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .linked       (out_ch.linked),
  .source_full  (out_ch.source_full),
  .skipped_full (out_ch.skipped_full),
  .last         (out_ch.last)
);
`default_nettype wire

[tb/sv/tb_degree_capped_radius_neighbor_linker.sv]
// Testbench: drives loads and visits into the neighbor linker and checks every result beat.
`timescale 1ns / 1ps
module tb_degree_capped_radius_neighbor_linker;

  localparam int NPART = dcrnl_pkg::DEF_MAX_PARTICLES;
  localparam int NLINK = dcrnl_pkg::DEF_MAX_LINKS;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam logic [dcrnl_pkg::ADDR_W-1:0] ADDR_COUNT = {dcrnl_pkg::REG_PCOUNT, 3'b000};
  localparam logic [dcrnl_pkg::ADDR_W-1:0] ADDR_LIMIT = {dcrnl_pkg::REG_LIMIT, 3'b000};

  typedef struct packed {
    logic                           func;
    logic [dcrnl_pkg::IDX_W-1:0]    idx;
    logic [dcrnl_pkg::POS_W-1:0]    px;
    logic [dcrnl_pkg::POS_W-1:0]    py;
    logic [dcrnl_pkg::POS_W-1:0]    pz;
  } item_t;

  typedef struct packed {
    logic                           linked;
    logic [dcrnl_pkg::IDX_W-1:0]    src;
    logic [dcrnl_pkg::IDX_W-1:0]    dst;
    logic [dcrnl_pkg::SLOT_W-1:0]   src_slot;
    logic [dcrnl_pkg::SLOT_W-1:0]   dst_slot;
    logic [dcrnl_pkg::LEN_W-1:0]    len;
    logic                           full;
    logic [dcrnl_pkg::SKIP_W-1:0]   skipped;
    logic                           last;
  } link_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [dcrnl_pkg::ADDR_W-1:0] paddr = '0;
  logic [dcrnl_pkg::DATA_W-1:0] pwdata = '0;
  logic [dcrnl_pkg::DATA_W-1:0] prdata;
  logic pready;

  dcrnl_in_if  in_if();
  dcrnl_out_if out_if();

  degree_capped_radius_neighbor_linker DUT (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_ch(in_if), .out_ch(out_if)
  );

  always #5 clk = ~clk;

  item_t       pending_items[$];
  link_beat_t  expected_links[$];
  int          errors = 0;
  longint      cycles = 0;
  int          hold_token = 0;

  logic [3*dcrnl_pkg::POS_W-1:0] pos_mem [NPART];
  int unsigned                   fill_mem [NPART];
  logic [dcrnl_pkg::PCNT_W-1:0]  cfg_count = dcrnl_pkg::PCNT_RESET;
  logic [dcrnl_pkg::LIM_W-1:0]   cfg_limit = dcrnl_pkg::LIM_RESET;

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, t;
    r = 0;
    for (int i = 17; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic longint unsigned dist_sq(logic [3*dcrnl_pkg::POS_W-1:0] p,
                                              logic [3*dcrnl_pkg::POS_W-1:0] q);
    longint unsigned s;
    longint d;
    s = 0;
    for (int k = 0; k < 3; k++) begin
      d = longint'($signed(p[k*dcrnl_pkg::POS_W +: dcrnl_pkg::POS_W]))
          - longint'($signed(q[k*dcrnl_pkg::POS_W +: dcrnl_pkg::POS_W]));
      s += longint'(d * d);
    end
    return s;
  endfunction

  task automatic add_item(item_t it);
    pending_items.insert(pending_items.size(), it);
  endtask

  task automatic add_expect(link_beat_t r);
    expected_links.insert(expected_links.size(), r);
  endtask

  task automatic predict_item(item_t it);
    link_beat_t r, found[$];
    int unsigned a, n, fa, skipped;
    longint unsigned d2;
    a = it.idx;
    skipped = 0;
    if (it.func == dcrnl_pkg::FUNC_LOAD) begin
      pos_mem[a] = {it.pz, it.py, it.px};
      fill_mem[a] = 0;
      return;
    end
    r = '0;
    r.src = it.idx;
    r.last = 1'b1;
    fa = fill_mem[a];
    if (fa >= NLINK) begin
      r.full = 1'b1;
      add_expect(r);
      return;
    end
    if (cfg_limit == 0) begin
      add_expect(r);
      return;
    end
    n = (cfg_count > NPART) ? NPART : cfg_count;
    for (int unsigned b = 0; b < n; b++) begin
      if (b == a) continue;
      d2 = dist_sq(pos_mem[a], pos_mem[b]);
      if (d2 > cfg_limit) continue;
      if (fill_mem[b] >= NLINK) begin
        if (skipped < 1023) skipped++;
        continue;
      end
      r.linked = 1'b1;
      r.dst = b[dcrnl_pkg::IDX_W-1:0];
      r.src_slot = fa[dcrnl_pkg::SLOT_W-1:0];
      r.dst_slot = fill_mem[b][dcrnl_pkg::SLOT_W-1:0];
      r.len = dcrnl_pkg::LEN_W'(root_floor(d2));
      r.last = 1'b0;
      found.insert(found.size(), r);
      fill_mem[b]++;
      fa++;
      fill_mem[a] = fa;
      if (fa >= NLINK || found.size() >= dcrnl_pkg::RES_CAP) break;
    end
    if (found.size() == 0) begin
      r = '0;
      r.src = it.idx;
      r.last = 1'b1;
      r.skipped = dcrnl_pkg::SKIP_W'(skipped);
      add_expect(r);
      return;
    end
    foreach (found[i]) begin
      found[i].skipped = dcrnl_pkg::SKIP_W'(skipped);
      if (i == found.size() - 1) found[i].last = 1'b1;
      add_expect(found[i]);
    end
  endtask

  item_t cur_item;
  int burst_left = 0, gap_left = 0;

  always @(posedge clk) begin
    logic acc;
    logic nv;
    item_t nx;
    if (rst) begin
      in_if.valid <= 1'b0;
      in_if.func <= 1'b0;
      in_if.particle_index <= '0;
      in_if.pos_x <= '0;
      in_if.pos_y <= '0;
      in_if.pos_z <= '0;
    end else begin
      acc = in_if.valid && in_if.ready;
      nv = in_if.valid;
      nx = cur_item;
      if (acc) begin
        predict_item(cur_item);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          burst_left = $urandom_range(1, 20);
        end
      end
      if (!in_if.valid || acc) begin
        if (gap_left > 0) begin
          gap_left--;
          nv = 1'b0;
        end else if (pending_items.size() > 0) begin
          nx = pending_items.pop_front();
          nv = 1'b1;
        end else begin
          nv = 1'b0;
        end
      end
      cur_item = nx;
      in_if.valid <= nv;
      in_if.func <= nx.func;
      in_if.particle_index <= nx.idx;
      in_if.pos_x <= nx.px;
      in_if.pos_y <= nx.py;
      in_if.pos_z <= nx.pz;
    end
  end

  int stall_mode = 0, mode_left = 0, hold_left = 0, hold_seen = 0;

  always @(posedge clk) begin
    link_beat_t got, exp_r;
    logic nr;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
    if (!rst) begin
      if (out_if.valid && out_if.ready) begin
        got = {out_if.linked, out_if.source_index, out_if.partner_index, out_if.source_slot,
               out_if.partner_slot, out_if.link_length, out_if.source_full,
               out_if.skipped_full, out_if.last};
        if (expected_links.size() == 0) begin
          $error("result beat with nothing expected: %p", got);
          errors++;
        end else begin
          exp_r = expected_links.pop_front();
          if (got.linked !== exp_r.linked) begin
            $error("linked exp %0d got %0d", exp_r.linked, got.linked); errors++;
          end
          if (got.src !== exp_r.src) begin
            $error("source_index exp %0d got %0d", exp_r.src, got.src); errors++;
          end
          if (got.dst !== exp_r.dst) begin
            $error("partner_index exp %0d got %0d", exp_r.dst, got.dst); errors++;
          end
          if (got.src_slot !== exp_r.src_slot) begin
            $error("source_slot exp %0d got %0d", exp_r.src_slot, got.src_slot); errors++;
          end
          if (got.dst_slot !== exp_r.dst_slot) begin
            $error("partner_slot exp %0d got %0d", exp_r.dst_slot, got.dst_slot); errors++;
          end
          if (got.len !== exp_r.len) begin
            $error("link_length exp %0d got %0d", exp_r.len, got.len); errors++;
          end
          if (got.full !== exp_r.full) begin
            $error("source_full exp %0d got %0d", exp_r.full, got.full); errors++;
          end
          if (got.skipped !== exp_r.skipped) begin
            $error("skipped_full exp %0d got %0d", exp_r.skipped, got.skipped); errors++;
          end
          if (got.last !== exp_r.last) begin
            $error("last exp %0d got %0d", exp_r.last, got.last); errors++;
          end
        end
      end
    end
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = 4000;
    end
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left = $urandom_range(20, 300);
    end else begin
      mode_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      nr = 1'b0;
    end else begin
      case (stall_mode)
        0: nr = 1'b1;
        1: nr = ($urandom_range(0, 1) == 0);
        2: nr = ($urandom_range(0, 7) != 0);
        default: nr = ($urandom_range(0, 7) == 0);
      endcase
    end
    out_if.ready <= nr;
  end

  task automatic apb_write(logic [dcrnl_pkg::ADDR_W-1:0] addr,
                           logic [dcrnl_pkg::DATA_W-1:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (addr == ADDR_COUNT) cfg_count = data[dcrnl_pkg::PCNT_W-1:0];
    else cfg_limit = data[dcrnl_pkg::LIM_W-1:0];
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain_wait();
    while (pending_items.size() > 0 || in_if.valid || expected_links.size() > 0)
      @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  task automatic set_config(int unsigned count, longint unsigned limit);
    drain_wait();
    apb_write(ADDR_COUNT, dcrnl_pkg::DATA_W'(count));
    apb_write(ADDR_LIMIT, dcrnl_pkg::DATA_W'(limit));
  endtask

  function automatic item_t make_load(int unsigned idx, int spread);
    item_t it;
    it.func = dcrnl_pkg::FUNC_LOAD;
    it.idx = dcrnl_pkg::IDX_W'(idx);
    if (spread == 0) begin
      it.px = dcrnl_pkg::POS_W'($urandom);
      it.py = dcrnl_pkg::POS_W'($urandom);
      it.pz = dcrnl_pkg::POS_W'($urandom);
    end else begin
      it.px = dcrnl_pkg::POS_W'(int'($urandom_range(0, 2 * spread)) - spread);
      it.py = dcrnl_pkg::POS_W'(int'($urandom_range(0, 2 * spread)) - spread);
      it.pz = dcrnl_pkg::POS_W'(int'($urandom_range(0, 2 * spread)) - spread);
    end
    return it;
  endfunction

  function automatic item_t make_visit(int unsigned idx);
    item_t it;
    it = '0;
    it.func = dcrnl_pkg::FUNC_VISIT;
    it.idx = dcrnl_pkg::IDX_W'(idx);
    return it;
  endfunction

  task automatic load_all(int unsigned n, int spread);
    for (int unsigned i = 0; i < n; i++) add_item(make_load(i, spread));
  endtask

  initial begin
    item_t it;
    int unsigned n;
    longint unsigned lim;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // tight cluster: every pair in range, A fills, then reports full
    set_config(12, dcrnl_pkg::LIM_RESET);
    load_all(12, 25);
    add_item(make_visit(0));
    add_item(make_visit(0));
    add_item(make_visit(11));
    add_item(make_visit(5));
    add_item(make_visit(3));

    // extreme coordinates, widest limit
    set_config(12, 64'hF_FFFF_FFFF);
    load_all(10, 0);
    it = make_load(10, 1); it.px = 16'h7FFF; it.py = 16'h7FFF; it.pz = 16'h7FFF;
    add_item(it);
    it = make_load(11, 1); it.px = 16'h8000; it.py = 16'h8000; it.pz = 16'h8000;
    add_item(it);
    add_item(make_visit(10));
    add_item(make_visit(2));
    add_item(make_visit(11));

    set_config(12, 0);
    add_item(make_visit(4));
    add_item(make_visit(10));

    set_config(0, 1);
    add_item(make_visit(7));

    // highest index against partly full partners
    set_config(12, 64'hF_FFFF_FFFF);
    add_item(make_load(NPART - 1, 0));
    add_item(make_visit(NPART - 1));

    for (int ph = 0; ph < 8; ph++) begin
      n = $urandom_range(2, 16);
      case ($urandom_range(0, 3))
        0: lim = dcrnl_pkg::LIM_RESET;
        1: lim = $urandom_range(1, 200000);
        2: lim = {$urandom, $urandom} & 64'hF_FFFF_FFFF;
        default: lim = $urandom_range(1, 20);
      endcase
      set_config(n, lim);
      load_all(n, ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(5, 60));
      if (ph == 3) hold_token++;
      for (int i = 0; i < 18; i++) begin
        if ($urandom_range(0, 9) < 6) add_item(make_visit($urandom_range(0, n - 1)));
        else add_item(make_load($urandom_range(0, n - 1), 30));
      end
    end

    drain_wait();
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
